// ===== rtl/tpdc_pkg.sv =====
`timescale 1ns / 1ps

package tpdc_pkg;

  // coordinate and register widths
  localparam int COORD_W  = 16;
  localparam int THRESH_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int KIND_W = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  // request types
  localparam logic REQ_POINT = 1'b0;
  localparam logic REQ_END   = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_APPEND       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND_CLOSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE        = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

  typedef struct packed {
    logic              req_type;
    coord_t            x;
    coord_t            y;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    coord_t            x;
    coord_t            y;
    logic              last;
  } result_t;

endpackage

// ===== rtl/tpdc_if.sv =====
`timescale 1ns / 1ps

// trace point input channel
interface tpdc_in_if import tpdc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, output req_type, output point_x, output point_y,
                  input ready);
  modport sink   (input valid, input req_type, input point_x, input point_y,
                  output ready);
endinterface

// polyline command output channel
interface tpdc_out_if import tpdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  coord_t            out_x;
  coord_t            out_y;
  logic              last_of_run;

  modport source (output valid, output out_kind, output out_x, output out_y,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_kind, input out_x, input out_y,
                  input last_of_run, output ready);
endinterface

// register write channel
interface tpdc_cfg_if import tpdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/trace_point_decimate_clip_unit.sv =====
`timescale 1ns / 1ps

// Trace point decimator and rectangle clipper. Each trace point transaction on
// in_chan after the first of a trace is compared with the last kept point: it
// is kept only when its squared distance exceeds the threshold register, and
// kept points are turned into polyline commands on out_chan (append, append
// then close, close only), clipped to the inclusive rectangle held in the bound
// registers. An end of trace transaction flushes the latest unkept point when
// it is drawable and always closes the polyline. A point that is dropped gives
// no output transaction; a re-entry into the rectangle gives two, with
// last_of_run set on the second. Rate: an item that causes at most one result
// is taken every cycle while out_chan is ready; one that causes two results
// holds the single result port until both have gone out, and the next item
// waits. An accepted item passes through one input register, then the decision
// logic (one 16x16 square per axis, a 33-bit sum and compare) writes a
// two-entry result queue that drives out_chan. The registers must be written
// only while the block is idle, which it does not enforce; cfg_ready is always high.

module trace_point_decimate_clip_unit import tpdc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  tpdc_in_if.sink        in_chan,
  tpdc_out_if.source     out_chan,
  tpdc_cfg_if.sink       cfg_chan
);

  // inclusive rectangle test
  function automatic logic pt_in_rect(input coord_t px, input coord_t py,
                                      input coord_t l, input coord_t t,
                                      input coord_t r, input coord_t b);
    pt_in_rect = (px >= l) && (px <= r) && (py >= t) && (py <= b);
  endfunction

  // configuration registers
  coord_t              left_r, top_r, right_r, bottom_r;
  logic [THRESH_W-1:0] thresh_r;

  // tracking state
  logic   awaiting_first_r, awaiting_first_nxt;
  logic   drawing_active_r, drawing_active_nxt;
  coord_t kept_x_r, kept_x_nxt, kept_y_r, kept_y_nxt;
  coord_t latest_x_r, latest_x_nxt, latest_y_r, latest_y_nxt;

  // input register
  item_t item_r;
  logic  item_valid_r, item_valid_nxt;

  // result queue, entry 0 is the head
  result_t    q_r [2];
  result_t    q0_nxt, q1_nxt;
  logic [1:0] q_count_r, q_count_nxt;

  logic       in_xfer, out_pop, process;
  logic [1:0] q_left;

  // decision results
  result_t    res0, res1;
  logic [1:0] n_res;

  // distance datapath
  logic [COORD_W:0]     dx, dy, dx_neg, dy_neg;
  logic [COORD_W-1:0]   adx, ady;
  logic [2*COORD_W-1:0] sqx, sqy;
  logic [2*COORD_W:0]   dist_sq;
  logic                 far, pt_in, latest_in, latest_moved;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;

  assign out_pop = out_chan.valid && out_chan.ready;
  // occupancy once the head transaction has gone out this cycle
  assign q_left  = q_count_r - {1'b0, out_pop};
  // an item is resolved only into an empty queue, room for two results
  assign process = item_valid_r && (q_left == 2'd0);

  assign in_chan.ready = !item_valid_r || process;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = (q_count_r != 2'd0);
  assign out_chan.out_kind    = q_r[0].kind;
  assign out_chan.out_x       = q_r[0].x;
  assign out_chan.out_y       = q_r[0].y;
  assign out_chan.last_of_run = q_r[0].last;

  // ---------------------------------------------------------------------------
  // squared distance from the last kept point, exact in 33 bits
  // ---------------------------------------------------------------------------
  assign dx      = {item_r.x[COORD_W-1], item_r.x} - {kept_x_r[COORD_W-1], kept_x_r};
  assign dy      = {item_r.y[COORD_W-1], item_r.y} - {kept_y_r[COORD_W-1], kept_y_r};
  assign dx_neg  = -dx;
  assign dy_neg  = -dy;
  assign adx     = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
  assign ady     = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
  assign sqx     = adx * adx;
  assign sqy     = ady * ady;
  assign dist_sq = {1'b0, sqx} + {1'b0, sqy};
  assign far     = dist_sq > {1'b0, thresh_r};

  assign pt_in        = pt_in_rect(item_r.x, item_r.y, left_r, top_r, right_r, bottom_r);
  assign latest_in    = pt_in_rect(latest_x_r, latest_y_r, left_r, top_r, right_r,
                                   bottom_r);
  assign latest_moved = (latest_x_r != kept_x_r) || (latest_y_r != kept_y_r);

  // ---------------------------------------------------------------------------
  // per-item decision
  // ---------------------------------------------------------------------------
  always_comb begin
    res0               = '0;
    res1               = '0;
    n_res              = 2'd0;
    awaiting_first_nxt = awaiting_first_r;
    drawing_active_nxt = drawing_active_r;
    kept_x_nxt         = kept_x_r;
    kept_y_nxt         = kept_y_r;
    latest_x_nxt       = latest_x_r;
    latest_y_nxt       = latest_y_r;

    if (item_r.req_type == REQ_END) begin
      // flush the latest unkept point if it is drawable, always close
      if (!awaiting_first_r && latest_moved && (drawing_active_r || latest_in)) begin
        res0 = '{kind: KIND_APPEND_CLOSE, x: latest_x_r, y: latest_y_r, last: 1'b1};
      end else begin
        res0 = '{kind: KIND_CLOSE, x: '0, y: '0, last: 1'b1};
      end
      n_res              = 2'd1;
      awaiting_first_nxt = 1'b1;
      drawing_active_nxt = 1'b0;
    end else begin
      if (awaiting_first_r) begin
        // first point of a trace: appended when inside, drawing stays off
        awaiting_first_nxt = 1'b0;
        kept_x_nxt         = item_r.x;
        kept_y_nxt         = item_r.y;
        if (pt_in) begin
          res0  = '{kind: KIND_APPEND, x: item_r.x, y: item_r.y, last: 1'b1};
          n_res = 2'd1;
        end
      end else if (far) begin
        if (drawing_active_r) begin
          if (pt_in) begin
            res0  = '{kind: KIND_APPEND, x: item_r.x, y: item_r.y, last: 1'b1};
          end else begin
            // leaving the rectangle ends the polyline
            res0  = '{kind: KIND_APPEND_CLOSE, x: item_r.x, y: item_r.y, last: 1'b1};
            drawing_active_nxt = 1'b0;
          end
          n_res = 2'd1;
        end else if (pt_in) begin
          // re-entry: previous kept point, then this one
          res0  = '{kind: KIND_APPEND, x: kept_x_r, y: kept_y_r, last: 1'b0};
          res1  = '{kind: KIND_APPEND, x: item_r.x, y: item_r.y, last: 1'b1};
          n_res = 2'd2;
          drawing_active_nxt = 1'b1;
        end
        kept_x_nxt = item_r.x;
        kept_y_nxt = item_r.y;
      end
      latest_x_nxt = item_r.x;
      latest_y_nxt = item_r.y;
    end
  end

  // ---------------------------------------------------------------------------
  // input register and result queue next values
  // ---------------------------------------------------------------------------
  always_comb begin
    if (in_xfer) begin
      item_valid_nxt = 1'b1;
    end else if (process) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end

    q0_nxt      = out_pop ? q_r[1] : q_r[0];
    q1_nxt      = q_r[1];
    q_count_nxt = q_left;
    if (process) begin
      q0_nxt      = res0;
      q1_nxt      = res1;
      q_count_nxt = n_res;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
      thresh_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        CFG_LEFT:      left_r   <= cfg_chan.data[COORD_W-1:0];
        CFG_TOP:       top_r    <= cfg_chan.data[COORD_W-1:0];
        CFG_RIGHT:     right_r  <= cfg_chan.data[COORD_W-1:0];
        CFG_BOTTOM:    bottom_r <= cfg_chan.data[COORD_W-1:0];
        CFG_THRESHOLD: thresh_r <= cfg_chan.data[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_first_r <= 1'b1;
      drawing_active_r <= 1'b0;
      kept_x_r         <= '0;
      kept_y_r         <= '0;
      latest_x_r       <= '0;
      latest_y_r       <= '0;
      item_valid_r     <= 1'b0;
      q_count_r        <= 2'd0;
    end else begin
      if (process) begin
        awaiting_first_r <= awaiting_first_nxt;
        drawing_active_r <= drawing_active_nxt;
        kept_x_r         <= kept_x_nxt;
        kept_y_r         <= kept_y_nxt;
        latest_x_r       <= latest_x_nxt;
        latest_y_r       <= latest_y_nxt;
      end
      item_valid_r <= item_valid_nxt;
      q_count_r    <= q_count_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= '{req_type: in_chan.req_type, x: in_chan.point_x, y: in_chan.point_y};
    end
    q_r[0] <= q0_nxt;
    q_r[1] <= q1_nxt;
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // the result queue never holds more than two transactions
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r != 2'd3)
    else $error("result queue overflow");

  // with two results queued the head is the first of a pair
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count_r == 2'd2) |-> (!q_r[0].last && q_r[1].last))
    else $error("result pair out of order");

  // an end of trace rearms the first-point logic and stops drawing
  a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (process && (item_r.req_type == REQ_END)) |=> (awaiting_first_r && !drawing_active_r))
    else $error("end of trace did not rearm");

  // a close-only transaction carries a zero point
  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.out_kind == KIND_CLOSE)) |->
      ((out_chan.out_x == '0) && (out_chan.out_y == '0) && out_chan.last_of_run))
    else $error("close-only result carries a point");

endmodule

// ===== dv/polyline_checker.sv =====
`timescale 1ns / 1ps

module polyline_checker import tpdc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tpdc_in_if   in_mon,
  tpdc_out_if  out_mon,
  tpdc_cfg_if  cfg_mon,
  output int   mismatches,
  output int   pending
);

  coord_t              left_b, top_b, right_b, bottom_b;
  logic [THRESH_W-1:0] min_dist2;
  logic                awaiting_first, drawing;
  coord_t              kept_x, kept_y, latest_x, latest_y;
  result_t             expected_cmds[$];
  int                  errs = 0;

  function automatic logic in_rect(coord_t x, coord_t y);
    return x >= left_b && x <= right_b && y >= top_b && y <= bottom_b;
  endfunction

  function automatic longint dist2(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic void note(string msg);
    if (errs < 10) $display("%0t ns: %s", $time, msg);
    errs++;
  endfunction

  task automatic predict_commands(logic req, coord_t x, coord_t y);
    result_t cmds[$];
    logic    now_in;
    if (req == REQ_END) begin
      if (!awaiting_first && (latest_x != kept_x || latest_y != kept_y) &&
          (drawing || in_rect(latest_x, latest_y)))
        cmds.push_back('{KIND_APPEND_CLOSE, latest_x, latest_y, 1'b0});
      else
        cmds.push_back('{KIND_CLOSE, '0, '0, 1'b0});
      awaiting_first = 1'b1;
      drawing        = 1'b0;
    end else begin
      if (awaiting_first) begin
        // first point is kept, and shown when inside, but the polyline is not yet open
        awaiting_first = 1'b0;
        kept_x = x;
        kept_y = y;
        if (in_rect(x, y)) cmds.push_back('{KIND_APPEND, x, y, 1'b0});
      end else if (dist2(x, y, kept_x, kept_y) > longint'(min_dist2)) begin
        now_in = in_rect(x, y);
        if (drawing) begin
          if (now_in) begin
            cmds.push_back('{KIND_APPEND, x, y, 1'b0});
          end else begin
            cmds.push_back('{KIND_APPEND_CLOSE, x, y, 1'b0});
            drawing = 1'b0;
          end
        end else if (now_in) begin
          // re-entry: previous kept point opens the new polyline
          cmds.push_back('{KIND_APPEND, kept_x, kept_y, 1'b0});
          cmds.push_back('{KIND_APPEND, x, y, 1'b0});
          drawing = 1'b1;
        end
        kept_x = x;
        kept_y = y;
      end
      latest_x = x;
      latest_y = y;
    end
    if (cmds.size() > 0) cmds[cmds.size()-1].last = 1'b1;
    foreach (cmds[i]) expected_cmds.push_back(cmds[i]);
  endtask

  task automatic check_command();
    result_t want;
    if (expected_cmds.size() == 0) begin
      note($sformatf("unexpected command kind=%0d x=%0d y=%0d last=%0b",
                     out_mon.out_kind, out_mon.out_x, out_mon.out_y, out_mon.last_of_run));
      return;
    end
    want = expected_cmds.pop_front();
    if (out_mon.out_kind !== want.kind || out_mon.out_x !== want.x ||
        out_mon.out_y !== want.y || out_mon.last_of_run !== want.last)
      note($sformatf({"command mismatch: expected kind=%0d x=%0d y=%0d last=%0b, ",
                      "got kind=%0d x=%0d y=%0d last=%0b"},
                     want.kind, want.x, want.y, want.last, out_mon.out_kind,
                     out_mon.out_x, out_mon.out_y, out_mon.last_of_run));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      left_b         = '0;
      top_b          = '0;
      right_b        = '0;
      bottom_b       = '0;
      min_dist2      = '0;
      awaiting_first = 1'b1;
      drawing        = 1'b0;
      kept_x         = '0;
      kept_y         = '0;
      latest_x       = '0;
      latest_y       = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_LEFT:      left_b    = cfg_mon.data[COORD_W-1:0];
          CFG_TOP:       top_b     = cfg_mon.data[COORD_W-1:0];
          CFG_RIGHT:     right_b   = cfg_mon.data[COORD_W-1:0];
          CFG_BOTTOM:    bottom_b  = cfg_mon.data[COORD_W-1:0];
          CFG_THRESHOLD: min_dist2 = cfg_mon.data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_commands(in_mon.req_type, in_mon.point_x, in_mon.point_y);
      if (out_mon.valid && out_mon.ready) check_command();
    end
    pending    <= expected_cmds.size();
    mismatches <= errs;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tpdc_pkg::*;

  // longest quiet stretch in a correct run is a sender gap plus the settle
  // pause plus a receiver stall; this limit is far above it
  localparam int IDLE_LIMIT    = 2000;
  // input register then result queue, so a dropped point may still be in flight
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  tpdc_in_if  in_if ();
  tpdc_out_if out_if ();
  tpdc_cfg_if cfg_if ();

  int mismatches;
  int pending;

  trace_point_decimate_clip_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  polyline_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // when set, both sides run back to back with no idling
  bit calm = 1'b0;

  // random walk state, centered on the current clip rectangle
  int walk_x, walk_y, step_sz;
  int rect_l, rect_t, rect_r, rect_b;

  int n_points   = 0;
  int n_ends     = 0;
  int n_settings = 0;
  int n_results  = 0;
  int idle_cycles;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one trace transaction, after a random gap; valid stays high afterwards
  // so a following transaction with no gap does not glitch it
  task automatic send_item(logic req, int x, int y);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.point_x  <= 16'(x);
    in_if.point_y  <= 16'(y);
    do @(posedge clk); while (!in_if.ready);
    if (req == REQ_END) n_ends++;
    else n_points++;
  endtask

  // sender holds off until every predicted command has been drained
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // reprogram the rectangle and threshold while the block is idle;
  // unused upper bits of the bound writes get junk
  task automatic program_bounds(int l, int t, int r, int b, logic [31:0] thr, int step);
    wait_idle();
    cfg_write(CFG_LEFT,      {16'($urandom), 16'(l)});
    cfg_write(CFG_TOP,       {16'($urandom), 16'(t)});
    cfg_write(CFG_RIGHT,     {16'($urandom), 16'(r)});
    cfg_write(CFG_BOTTOM,    {16'($urandom), 16'(b)});
    cfg_write(CFG_THRESHOLD, thr);
    cfg_if.valid <= 1'b0;
    rect_l  = l;
    rect_t  = t;
    rect_r  = r;
    rect_b  = b;
    walk_x  = (l + r) / 2;
    walk_y  = (t + b) / 2;
    step_sz = step;
    n_settings++;
  endtask

  // mostly a trace-like walk, some hops onto the rectangle edges,
  // some full-range noise
  task automatic pick_point(output int px, output int py);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) begin
      walk_x = clamp16(walk_x + int'($urandom_range(0, 2 * step_sz)) - step_sz);
      walk_y = clamp16(walk_y + int'($urandom_range(0, 2 * step_sz)) - step_sz);
    end else if (sel < 17) begin
      walk_x = clamp16(($urandom_range(0, 1) ? rect_l : rect_r) +
                       int'($urandom_range(0, 4)) - 2);
      walk_y = clamp16(($urandom_range(0, 1) ? rect_t : rect_b) +
                       int'($urandom_range(0, 4)) - 2);
    end else begin
      walk_x = int'($urandom_range(0, 65535)) - 32768;
      walk_y = int'($urandom_range(0, 65535)) - 32768;
    end
    px = walk_x;
    py = walk_y;
  endtask

  task automatic random_stream(int n);
    int px, py;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 4) == 0);
      // halfway through, let the output side drain completely
      if (i == n / 2) wait_idle();
      if ($urandom_range(0, 11) == 0) begin
        send_item(REQ_END, $urandom, $urandom);
      end else begin
        pick_point(px, py);
        send_item(REQ_POINT, px, py);
      end
    end
  endtask

  // receiver: random stall before each command, with calm stretches
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) n_results <= n_results + 1;
  end

  // watchdog on transactions of any channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int l, t, w, h;
    in_if.valid     <= 1'b0;
    in_if.req_type  <= REQ_POINT;
    in_if.point_x   <= '0;
    in_if.point_y   <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_LEFT;
    cfg_if.data     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: rectangle +-100, threshold exactly 25
    program_bounds(-100, -100, 100, 100, 25, 10);
    send_item(REQ_END, 0, 0);          // end with nothing received
    send_item(REQ_POINT, 0, 0);        // first point inside
    send_item(REQ_POINT, 3, 4);        // distance equals threshold, dropped
    send_item(REQ_POINT, 5, 0);        // dropped as well
    send_item(REQ_POINT, 10, 0);       // first point repeated, then this one
    send_item(REQ_POINT, 20, 0);       // extends polyline
    send_item(REQ_POINT, 200, 0);      // leaves, closes
    send_item(REQ_POINT, 300, 0);      // outside while not drawing
    send_item(REQ_POINT, 50, 50);      // re-entry, two commands
    send_item(REQ_POINT, 52, 52);      // dropped
    send_item(REQ_END, 0, 0);          // flushes the dropped point
    send_item(REQ_POINT, 500, 500);    // first point outside
    send_item(REQ_END, 0, 0);          // latest equals kept, close only
    send_item(REQ_POINT, -100, -100);  // corner is inclusive
    send_item(REQ_POINT, 100, 100);    // opposite corner
    send_item(REQ_POINT, 100, 101);    // dropped, just outside
    send_item(REQ_END, 0, 0);          // drawing, so outside point is flushed
    send_item(REQ_POINT, -32768, -32768);
    send_item(REQ_POINT, -32767, -32768);
    send_item(REQ_END, 0, 0);          // not drawing and outside, close only

    // full plane with maximum threshold; only the corner-to-corner jump passes
    program_bounds(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 32767);
    send_item(REQ_POINT, -32768, -32768);
    send_item(REQ_POINT, 32767, 32767);
    send_item(REQ_END, 0, 0);

    // random phases, each under a different setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_bounds(0, 0, 0, 0, 0, 2);                 // single-point rectangle
        1: program_bounds(-1000, -1000, 1000, 1000, 10000, 300);
        2: program_bounds(500, -500, -500, 500, 10, 200);    // inverted in x
        3: program_bounds(-200, 300, 200, -300, 0, 150);     // inverted in y
        4: program_bounds(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 32767);
        5: program_bounds(32767, 32767, 32767, 32767, 0, 3); // top corner only
        6: begin
          l = int'($urandom_range(0, 62000)) - 32768;
          t = int'($urandom_range(0, 62000)) - 32768;
          w = $urandom_range(0, 2000);
          h = $urandom_range(0, 2000);
          program_bounds(l, t, l + w, t + h, $urandom_range(0, 50000), 400);
        end
        default: begin
          program_bounds(int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768,
                         $urandom, $urandom_range(1, 32767));
        end
      endcase
      random_stream(PHASE_ITEMS);
    end

    calm = 1'b0;
    wait_idle();
    $display("stimulus: %0d trace points and %0d end markers under %0d bound/threshold settings",
             n_points, n_ends, n_settings);
    $display("%0d polyline commands compared with prediction", n_results);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tpdc_pkg.sv
rtl/tpdc_if.sv
rtl/trace_point_decimate_clip_unit.sv
dv/polyline_checker.sv
dv/tb_top.sv
